// File: hdl/lrud_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrud_pkg;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 32;
  localparam int TOT_W  = 32;
  localparam int CAP_W  = 5;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_PROBE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 3'd0;
  localparam logic [CAP_W-1:0]  CAP_RESET     = 5'd16;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic start;    // capture the word and arm the scan trackers
    logic clear;    // empty the directory and zero the totals
    logic rd_scan;  // read one entry for the lookup pass
    logic rd_upd;   // read one entry for the rank update pass
    logic decide;   // resolve hit, eviction and placement
    logic load;     // move the result into the output register
  } lrud_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic in_clear;  // the offered word is a clear
    logic access;    // the held word is an access
    logic last;      // the entry index is on the last entry
  } lrud_stat_t;

endpackage

`default_nettype wire

// File: hdl/lrud_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lrud_ctrl import lrud_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire lrud_stat_t stat_i,
  output lrud_cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_SDRAIN = 7'b0000100,
    ST_DECIDE = 7'b0001000,
    ST_UPDATE = 7'b0010000,
    ST_UDRAIN = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (stat_i.in_clear) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_scan = 1'b1;
        if (stat_i.last) begin
          state_d = ST_SDRAIN;
        end
      end
      ST_SDRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = stat_i.access ? ST_UPDATE : ST_DONE;
      end
      ST_UPDATE: begin
        cmd_o.rd_upd = 1'b1;
        if (stat_i.last) begin
          state_d = ST_UDRAIN;
        end
      end
      ST_UDRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lrud_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lrud_datapath import lrud_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int STORE_W = 32,
  localparam int SLOT_W = $clog2(ENTRIES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lrud_cmd_t         cmd_i,
  output lrud_stat_t             stat_o,
  input  wire logic [OP_W-1:0]   in_op_i,
  input  wire logic [KEY_W-1:0]  in_key_i,
  input  wire logic [CAP_W-1:0]  cap_i,
  output logic                   out_hit_o,
  output logic [SLOT_W-1:0]      out_slot_o,
  output logic                   out_evicted_valid_o,
  output logic [KEY_W-1:0]       out_evicted_key_o,
  output logic [TOT_W-1:0]       out_hit_total_o,
  output logic [TOT_W-1:0]       out_miss_total_o
);

  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  // Entry stores.
  logic [STORE_W-1:0] key_mem  [ENTRIES];
  logic [SLOT_W-1:0]  rank_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [FILL_W-1:0]  fill_q;

  // Held word.
  logic [OP_W-1:0]    op_q;
  logic [STORE_W-1:0] key_q;

  // Entry walk and read pipeline.
  logic [SLOT_W-1:0]  idx_q;
  logic               rd_en;
  logic [STORE_W-1:0] rd_key_q;
  logic [SLOT_W-1:0]  rd_rank_q;
  logic [SLOT_W-1:0]  pidx_q;
  logic               pscan_q;
  logic               pupd_q;
  logic               entry_v;

  // Lookup trackers.
  logic               found_q;
  logic [SLOT_W-1:0]  found_idx_q;
  logic [SLOT_W-1:0]  found_rank_q;
  logic               old_any_q;
  logic [SLOT_W-1:0]  old_idx_q;
  logic [SLOT_W-1:0]  old_rank_q;
  logic [STORE_W-1:0] old_key_q;
  logic               free_any_q;
  logic [SLOT_W-1:0]  free_idx_q;

  // Decision and result.
  logic               need_evict;
  logic               evict;
  logic [SLOT_W-1:0]  place;
  logic               miss_ins;
  logic [ENTRIES-1:0] evict_mask;
  logic [ENTRIES-1:0] place_mask;
  logic [SLOT_W-1:0]  target_q;
  logic               upd_hit_q;
  logic [SLOT_W-1:0]  rank_new;
  logic [TOT_W-1:0]   hit_cnt_q;
  logic [TOT_W-1:0]   miss_cnt_q;
  logic               res_hit_q;
  logic [SLOT_W-1:0]  res_slot_q;
  logic               res_ev_q;
  logic [STORE_W-1:0] res_evkey_q;

  assign rd_en   = cmd_i.rd_scan || cmd_i.rd_upd;
  assign entry_v = valid_q[pidx_q];

  assign stat_o.in_clear = (in_op_i == OP_CLEAR);
  assign stat_o.access   = (op_q == OP_ACCESS);
  assign stat_o.last     = (idx_q == SLOT_W'(ENTRIES - 1));

  // A capacity of zero behaves as one; one above the entry count behaves as a full store.
  assign need_evict = (fill_q == FILL_W'(ENTRIES)) ||
                      ((cap_i == '0) && (fill_q != '0)) ||
                      ((cap_i != '0) && (CMP_W'(fill_q) >= CMP_W'(cap_i)));
  assign evict      = !found_q && old_any_q && need_evict;
  assign place      = (evict && (!free_any_q || (old_idx_q < free_idx_q))) ?
                      old_idx_q : free_idx_q;
  assign miss_ins   = cmd_i.decide && (op_q == OP_ACCESS) && !found_q;

  always_comb begin
    evict_mask = '0;
    place_mask = '0;
    if (evict) begin
      evict_mask[old_idx_q] = 1'b1;
    end
    place_mask[place] = 1'b1;
  end

  always_comb begin
    rank_new = rd_rank_q;
    if (pidx_q == target_q) begin
      rank_new = '0;
    end else if (entry_v && (!upd_hit_q || (rd_rank_q < found_rank_q))) begin
      rank_new = rd_rank_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_key_q  <= key_mem[idx_q];
      rd_rank_q <= rank_mem[idx_q];
    end
    if (miss_ins) begin
      key_mem[place] <= key_q;
    end
    if (pupd_q) begin
      rank_mem[pidx_q] <= rank_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      pscan_q <= 1'b0;
      pupd_q  <= 1'b0;
    end else begin
      pscan_q <= cmd_i.rd_scan;
      pupd_q  <= cmd_i.rd_upd;
      if (rd_en) begin
        idx_q <= stat_o.last ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= idx_q;
    if (cmd_i.start) begin
      op_q       <= in_op_i;
      key_q      <= in_key_i[STORE_W-1:0];
      found_q    <= 1'b0;
      old_any_q  <= 1'b0;
      free_any_q <= 1'b0;
    end else if (pscan_q) begin
      if (entry_v && (rd_key_q == key_q) && !found_q) begin
        found_q      <= 1'b1;
        found_idx_q  <= pidx_q;
        found_rank_q <= rd_rank_q;
      end
      if (entry_v && (!old_any_q || (rd_rank_q > old_rank_q))) begin
        old_any_q  <= 1'b1;
        old_idx_q  <= pidx_q;
        old_rank_q <= rd_rank_q;
        old_key_q  <= rd_key_q;
      end
      if (!entry_v && !free_any_q) begin
        free_any_q <= 1'b1;
        free_idx_q <= pidx_q;
      end
    end
  end

  // Directory occupancy and totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      fill_q     <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      valid_q    <= '0;
      fill_q     <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else if (cmd_i.decide && (op_q == OP_ACCESS)) begin
      if (found_q) begin
        if (hit_cnt_q != '1) begin
          hit_cnt_q <= hit_cnt_q + 1'b1;
        end
      end else begin
        if (miss_cnt_q != '1) begin
          miss_cnt_q <= miss_cnt_q + 1'b1;
        end
        // The new key may land in the slot just vacated, so the placement bit wins.
        valid_q <= (valid_q & ~evict_mask) | place_mask;
        if (!evict) begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      res_hit_q   <= 1'b0;
      res_slot_q  <= '0;
      res_ev_q    <= 1'b0;
      res_evkey_q <= '0;
    end else if (cmd_i.decide) begin
      res_hit_q <= found_q;
      upd_hit_q <= found_q;
      if (op_q == OP_ACCESS) begin
        res_slot_q  <= found_q ? found_idx_q : place;
        target_q    <= found_q ? found_idx_q : place;
        res_ev_q    <= evict;
        res_evkey_q <= evict ? old_key_q : '0;
      end else begin
        res_slot_q  <= found_q ? found_idx_q : '0;
        res_ev_q    <= 1'b0;
        res_evkey_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_hit_o           <= res_hit_q;
      out_slot_o          <= res_slot_q;
      out_evicted_valid_o <= res_ev_q;
      out_evicted_key_o   <= KEY_W'(res_evkey_q);
      out_hit_total_o     <= hit_cnt_q;
      out_miss_total_o    <= miss_cnt_q;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lru_tag_directory.sv
// Fully associative tag directory with least-recently-used replacement.
// Input channel (in_valid_i / in_stall_o) carries one word: an op and a key.
// Access looks the key up, counts a hit or a miss, and on a miss places the
// key, evicting the least recent entry first once the fill reaches the
// capacity register. Probe only reports presence. Clear empties the store
// and zeroes both saturating totals.
// Output channel (out_valid_o / out_stall_i) returns one word per input word.
// An access makes one pass over the key and rank memories for the lookup,
// then one read-modify-write pass over the rank memory; a probe makes only
// the lookup pass and a clear makes neither. The result word is loaded into
// the output register once that register is free. A new input word is
// accepted only after the previous one has been loaded.
// The output register holds a finished word while the receiver stalls; the
// next input word is accepted and worked on meanwhile and waits at the end
// for that register to free up.
// Reset empties the directory, zeroes the totals and sets the capacity to 16.
// The capacity register sits at byte address 0 of the APB port.
`timescale 1ns / 1ps
`default_nettype none

module lru_tag_directory import lrud_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32,
  localparam int SLOT_W  = $clog2(ENTRIES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [OP_W-1:0]   in_op_i,
  input  wire logic [KEY_W-1:0]  in_key_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   out_hit_o,
  output logic [SLOT_W-1:0]      out_slot_o,
  output logic                   out_evicted_valid_o,
  output logic [KEY_W-1:0]       out_evicted_key_o,
  output logic [TOT_W-1:0]       out_hit_total_o,
  output logic [TOT_W-1:0]       out_miss_total_o
);

  // Keys are matched on their low KEY_BITS bits.
  localparam int STORE_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  logic [CAP_W-1:0] cap_q;
  logic             cfg_we;
  lrud_cmd_t        cmd;
  lrud_stat_t       stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY);
  assign prdata = (paddr == ADDR_CAPACITY) ? DATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  lrud_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lrud_datapath #(
    .ENTRIES (ENTRIES),
    .STORE_W (STORE_W)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .in_op_i             (in_op_i),
    .in_key_i            (in_key_i),
    .cap_i               (cap_q),
    .out_hit_o           (out_hit_o),
    .out_slot_o          (out_slot_o),
    .out_evicted_valid_o (out_evicted_valid_o),
    .out_evicted_key_o   (out_evicted_key_o),
    .out_hit_total_o     (out_hit_total_o),
    .out_miss_total_o    (out_miss_total_o)
  );

endmodule

`default_nettype wire

// File: test/tb_lru_tag_directory.sv
`timescale 1ns / 1ps

module tb_lru_tag_directory;
  import lrud_pkg::*;

  localparam int ENTRIES = 16;
  localparam int SLOT_W = 4;
  localparam int POOL_SIZE = 20;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;
  // The spare op code has no name in the package; it must act as a probe.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              ev_valid;
    logic [KEY_W-1:0]  ev_key;
    logic [TOT_W-1:0]  hit_total;
    logic [TOT_W-1:0]  miss_total;
  } dir_result_t;

  class dir_scoreboard;
    bit               live [ENTRIES];
    logic [KEY_W-1:0] tag [ENTRIES];
    int unsigned      age [ENTRIES];
    logic [TOT_W-1:0] hit_count;
    logic [TOT_W-1:0] miss_count;
    logic [CAP_W-1:0] capacity;
    dir_result_t      expected_q[$];
    int               errors;
    int               checked;
    int               hits_seen;
    int               evictions_seen;

    function new();
      capacity = CAP_RESET;
      errors = 0;
      checked = 0;
      hits_seen = 0;
      evictions_seen = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < ENTRIES; i++) begin
        live[i] = 1'b0;
        tag[i] = '0;
        age[i] = 0;
      end
      hit_count = '0;
      miss_count = '0;
    endfunction

    function int find_tag(logic [KEY_W-1:0] key);
      for (int i = 0; i < ENTRIES; i++) begin
        if (live[i] && tag[i] == key) return i;
      end
      return -1;
    endfunction

    // Works out the word the directory must return for an accepted input word.
    function void note_input(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
      dir_result_t res;
      int found;
      int fill;
      int limit;
      int oldest;
      int place;
      int unsigned rank;
      res = '0;
      if (op == OP_CLEAR) begin
        wipe();
      end else if (op == OP_ACCESS) begin
        found = find_tag(key);
        if (found >= 0) begin
          rank = age[found];
          for (int i = 0; i < ENTRIES; i++) begin
            if (live[i] && age[i] < rank) age[i]++;
          end
          age[found] = 0;
          if (hit_count != '1) hit_count++;
          res.hit = 1'b1;
          res.slot = found[SLOT_W-1:0];
        end else begin
          if (miss_count != '1) miss_count++;
          fill = 0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (live[i]) fill++;
          end
          limit = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : int'(capacity);
          // A lowered capacity still evicts only one entry per miss.
          if (fill >= limit) begin
            oldest = -1;
            for (int i = 0; i < ENTRIES; i++) begin
              if (live[i] && (oldest < 0 || age[i] > age[oldest])) oldest = i;
            end
            if (oldest >= 0) begin
              live[oldest] = 1'b0;
              res.ev_valid = 1'b1;
              res.ev_key = tag[oldest];
            end
          end
          place = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (live[i]) age[i]++;
            else if (place < 0) place = i;
          end
          if (place >= 0) begin
            live[place] = 1'b1;
            tag[place] = key;
            age[place] = 0;
            res.slot = place[SLOT_W-1:0];
          end
        end
      end else begin
        found = find_tag(key);
        if (found >= 0) begin
          res.hit = 1'b1;
          res.slot = found[SLOT_W-1:0];
        end
      end
      res.hit_total = hit_count;
      res.miss_total = miss_count;
      expected_q = {expected_q, res};
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    task check(dir_result_t got);
      dir_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.hit) hits_seen++;
      if (got.ev_valid) evictions_seen++;
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
      if (got.slot !== want.slot)
        report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
      if (got.ev_valid !== want.ev_valid)
        report_mismatch($sformatf("evicted_valid %b, want %b", got.ev_valid, want.ev_valid));
      if (got.ev_key !== want.ev_key)
        report_mismatch($sformatf("evicted_key %h, want %h", got.ev_key, want.ev_key));
      if (got.hit_total !== want.hit_total)
        report_mismatch($sformatf("hit_total %0d, want %0d", got.hit_total, want.hit_total));
      if (got.miss_total !== want.miss_total)
        report_mismatch($sformatf("miss_total %0d, want %0d", got.miss_total,
                                  want.miss_total));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   in_op_i;
  logic [KEY_W-1:0]  in_key_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              out_hit_o;
  logic [SLOT_W-1:0] out_slot_o;
  logic              out_evicted_valid_o;
  logic [KEY_W-1:0]  out_evicted_key_o;
  logic [TOT_W-1:0]  out_hit_total_o;
  logic [TOT_W-1:0]  out_miss_total_o;

  dir_scoreboard     sb = new();
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int                words_sent = 0;
  int                cycles = 0;

  lru_tag_directory dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_op_i             (in_op_i),
    .in_key_i            (in_key_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_hit_o           (out_hit_o),
    .out_slot_o          (out_slot_o),
    .out_evicted_valid_o (out_evicted_valid_o),
    .out_evicted_key_o   (out_evicted_key_o),
    .out_hit_total_o     (out_hit_total_o),
    .out_miss_total_o    (out_miss_total_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: takes words that are not stalled and throttles the receiver.
  always @(posedge clk_i) begin
    dir_result_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.hit = out_hit_o;
      seen.slot = out_slot_o;
      seen.ev_valid = out_evicted_valid_o;
      seen.ev_key = out_evicted_key_o;
      seen.hit_total = out_hit_total_o;
      seen.miss_total = out_miss_total_o;
      sb.check(seen);
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Leaves valid high after acceptance so back-to-back words need no gap.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_op_i <= op;
    in_key_i <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(op, key);
    words_sent++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes the capacity register, then reads it back.
  task automatic set_capacity(input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_CAPACITY;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.capacity = value[CAP_W-1:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[CAP_W-1:0] !== value[CAP_W-1:0])
      sb.report_mismatch($sformatf("capacity reads %0d, want %0d", prdata[CAP_W-1:0],
                                   value[CAP_W-1:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly keys from a small pool so that hits and evictions both occur.
  task automatic run_phase(input logic [DATA_W-1:0] cap, input int count,
                           input int send_pct, input int recv_pct);
    int pick;
    logic [OP_W-1:0] op;
    logic [KEY_W-1:0] key;
    wait_drain();
    set_capacity(cap);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 2) op = OP_CLEAR;
      else if (pick < 6) op = OP_SPARE;
      else if (pick < 26) op = OP_PROBE;
      else op = OP_ACCESS;
      key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(POOL_SIZE - 1)];
      send_word(op, key);
      if (n == count / 2) wait_drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    in_op_i = OP_ACCESS;
    in_key_i = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 35;
    stall_pct = 71;
    set_capacity(32'd3);
    send_word(OP_ACCESS, 32'h0000_0000);
    send_word(OP_ACCESS, 32'hFFFF_FFFF);
    send_word(OP_ACCESS, 32'h0000_0000);
    send_word(OP_ACCESS, 32'hA5A5_A5A5);
    send_word(OP_ACCESS, 32'h5A5A_5A5A);
    send_word(OP_PROBE, 32'h0000_0000);
    send_word(OP_PROBE, 32'hFFFF_FFFF);
    send_word(OP_SPARE, 32'hA5A5_A5A5);
    send_word(OP_SPARE, 32'h1234_5678);
    // Capacity zero acts as one and lies below the current fill of three.
    wait_drain();
    set_capacity(32'd0);
    send_word(OP_ACCESS, 32'h0000_0000);
    send_word(OP_ACCESS, 32'h0000_0001);
    send_word(OP_ACCESS, 32'h8000_0000);
    send_word(OP_PROBE, 32'h0000_0001);
    send_word(OP_CLEAR, 32'hDEAD_BEEF);
    send_word(OP_PROBE, 32'h0000_0000);
    send_word(OP_ACCESS, 32'h8000_0000);
    send_word(OP_ACCESS, 32'h7FFF_FFFF);

    run_phase(32'd31, 190, 35, 71);
    // Upper data bits are not part of the register; the low bits give four.
    run_phase(32'hFFFF_FFE4, 190, 71, 35);
    run_phase(32'd16, 110, 0, 0);
    run_phase(32'd1, 50, 0, 0);

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d words, checked %0d results: %0d hits, %0d evictions.",
             words_sent, sb.checked, sb.hits_seen, sb.evictions_seen);
    $display("Capacities 3, 0, 31, 4, 16 and 1 with access, probe, spare op and clear.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/lrud_pkg.sv
hdl/lrud_ctrl.sv
hdl/lrud_datapath.sv
hdl/lru_tag_directory.sv
test/tb_lru_tag_directory.sv
